>>> rtl/core/sha512_pkg.sv
//------------------------------------------------------------------------------
// sha512_pkg: shared types and constants of the SHA-512 hash engine
// Holds the transfer structs, the initial hash values and the round constants.
//------------------------------------------------------------------------------
`default_nettype none
package sha512_pkg;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        final_word;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_digest_word;
    } t_out_item;

    // Schedule memory port bundle from the control unit.
    typedef struct packed {
        logic        we;
        logic [3:0]  waddr;
        logic [63:0] wdata;
        logic [3:0]  ra0;
        logic [3:0]  ra1;
        logic [3:0]  ra2;
        logic [3:0]  ra3;
    } t_sched_port;

    localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;
    localparam logic [6:0]  LAST_ROUND = 7'd79;

    function automatic logic [63:0] init_hash(input logic [2:0] i);
        logic [63:0] r;
        unique case (i)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            default: r = 64'h5be0cd19137e2179;
        endcase
        return r;
    endfunction

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage
`default_nettype wire

>>> rtl/core/sha512_sched_mem.sv
//------------------------------------------------------------------------------
// sha512_sched_mem: sixteen-word schedule window
// One write port and four registered read ports.
//------------------------------------------------------------------------------
`default_nettype none
module sha512_sched_mem (
    input  wire logic                      i_clk,
    input  wire sha512_pkg::t_sched_port   i_port,
    output logic [63:0]                    o_rd0,
    output logic [63:0]                    o_rd1,
    output logic [63:0]                    o_rd2,
    output logic [63:0]                    o_rd3
);
    logic [63:0] mem [16];

    always_ff @(posedge i_clk) begin
        if (i_port.we) begin
            mem[i_port.waddr] <= i_port.wdata;
        end
        o_rd0 <= mem[i_port.ra0];
        o_rd1 <= mem[i_port.ra1];
        o_rd2 <= mem[i_port.ra2];
        o_rd3 <= mem[i_port.ra3];
    end
endmodule
`default_nettype wire

>>> rtl/core/sha512_hash_engine_unit.sv
//------------------------------------------------------------------------------
// sha512_hash_engine_unit: SHA-512 message hash engine
// Message words go into a schedule memory; each full block runs 80 rounds.
//------------------------------------------------------------------------------
// A non-final word that does not complete a block leaves the block idle and
// busy low. The word that completes a 128-byte block holds busy while the
// block loads the working variables, runs each round as a registered schedule
// read and then the round itself with the write-back of the new schedule word,
// and adds into the hash. A final word fills the rest of its block at one word
// a cycle and compresses it; when the 0x80 byte and the length do not both
// fit, one more block is filled and compressed. The eight digest words then
// come out back to back on o_valid with busy still high; the receiver cannot
// stall them. After the digest the block is back in reset state, ready for the
// next message.
`default_nettype none
module sha512_hash_engine_unit (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire sha512_pkg::t_in_item   i_item,
    output logic                        o_valid,
    output sha512_pkg::t_out_item       o_item
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_INIT  = 7'b0000100,
        S_RD    = 7'b0001000,
        S_RND   = 7'b0010000,
        S_ADD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state       r_state, n_state;
    logic [63:0]  r_h [8];
    logic [63:0]  r_v [8];
    logic [3:0]   r_wib;
    logic [63:0]  r_bits;
    logic [6:0]   r_rnd;
    logic         r_pad;      // padding sequence active
    logic         r_after;    // 0x80 word still owed in the next pad slot
    logic         r_spill;    // length does not fit in the current block
    logic [2:0]   r_oidx;

    sha512_pkg::t_sched_port port;
    logic [63:0] rd0, rd1, rd2, rd3;

    sha512_sched_mem u_mem (
        .i_clk (i_clk),
        .i_port(port),
        .o_rd0 (rd0),
        .o_rd1 (rd1),
        .o_rd2 (rd2),
        .o_rd3 (rd3)
    );

    logic        accept;
    logic [3:0]  vb;
    logic [63:0] mask, fin_word, pad_word;
    logic [63:0] w_new, w_use, s0, s1, t1, t2, e, a;
    logic [3:0]  t4;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign vb     = (i_item.valid_bytes > 4'd8) ? 4'd8 : i_item.valid_bytes;
    assign t4     = r_rnd[3:0];

    always_comb begin
        mask = '1;
        for (int k = 0; k < 8; k++) begin
            if (4'(k) >= vb) begin
                mask[63-8*k -: 8] = 8'h00;
            end
        end
        fin_word = i_item.message_word & mask;
        if (vb != 4'd8) begin
            fin_word[63 - 8*vb[2:0] -: 8] = 8'h80;
        end
    end

    // Padding word for the current slot.
    always_comb begin
        if (r_after) begin
            pad_word = sha512_pkg::PAD_WORD;
        end else if (r_wib == 4'd15 && !r_spill) begin
            pad_word = r_bits;
        end else begin
            pad_word = '0;
        end
    end

    // rd0 = w[t-15], rd1 = w[t-2], rd2 = w[t-7], rd3 = w[t-16], or w[t] for t < 16
    always_comb begin
        s0 = {rd0[0], rd0[63:1]} ^ {rd0[7:0], rd0[63:8]} ^ (rd0 >> 7);
        s1 = {rd1[18:0], rd1[63:19]} ^ {rd1[60:0], rd1[63:61]} ^ (rd1 >> 6);
        w_new = rd3 + s0 + s1 + rd2;
        w_use = (r_rnd >= 7'd16) ? w_new : rd3;
        e = r_v[4];
        a = r_v[0];
        t1 = r_v[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
           + ((e & r_v[5]) ^ (~e & r_v[6])) + sha512_pkg::ROUND_K[r_rnd] + w_use;
        t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
           + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_comb begin
        port.we    = 1'b0;
        port.waddr = r_wib;
        port.wdata = i_item.message_word;
        port.ra0   = t4 - 4'd15;
        port.ra1   = t4 - 4'd2;
        port.ra2   = t4 - 4'd7;
        port.ra3   = t4;
        if (r_state == S_IDLE && accept) begin
            port.we    = 1'b1;
            port.wdata = (i_item.final_word && vb != 4'd8) ? fin_word : i_item.message_word;
        end else if (r_state == S_PAD) begin
            port.we    = 1'b1;
            port.wdata = pad_word;
        end else if (r_state == S_RND && r_rnd >= 7'd16) begin
            port.we    = 1'b1;
            port.waddr = t4;
            port.wdata = w_new;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_wib == 4'd15) begin
                        n_state = S_INIT;
                    end else if (i_item.final_word) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD:  n_state = (r_wib == 4'd15) ? S_INIT : S_PAD;
            S_INIT: n_state = S_RD;
            S_RD:   n_state = S_RND;
            S_RND:  n_state = (r_rnd == sha512_pkg::LAST_ROUND) ? S_ADD : S_RD;
            S_ADD:  n_state = (r_after || r_spill) ? S_PAD : (r_pad ? S_OUT : S_IDLE);
            S_OUT:  n_state = (r_oidx == 3'd7) ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wib   <= '0;
            r_bits  <= '0;
            r_rnd   <= '0;
            r_pad   <= 1'b0;
            r_after <= 1'b0;
            r_spill <= 1'b0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha512_pkg::init_hash(3'(i));
                r_v[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_wib <= r_wib + 4'd1;
                        if (i_item.final_word) begin
                            r_bits  <= r_bits + {57'd0, vb, 3'd0};
                            r_pad   <= 1'b1;
                            // full final word: 0x80 still owed in the next slot
                            r_after <= (vb == 4'd8);
                            // 0x80 lands in slot 14 or 15: length goes to a new block
                            r_spill <= (vb == 4'd8) ? (r_wib == 4'd13 || r_wib == 4'd14)
                                                    : (r_wib >= 4'd14);
                        end else begin
                            r_bits <= r_bits + 64'd64;
                        end
                    end
                end
                S_PAD: begin
                    r_wib   <= r_wib + 4'd1;
                    r_after <= 1'b0;
                end
                S_INIT: begin
                    r_v <= r_h;
                    r_rnd <= '0;
                end
                S_RD: ;
                S_RND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 7'd1;
                end
                S_ADD: begin
                    r_rnd   <= '0;
                    r_spill <= 1'b0;
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                end
                S_OUT: begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        r_wib  <= '0;
                        r_bits <= '0;
                        r_pad  <= 1'b0;
                        for (int i = 0; i < 8; i++) begin
                            r_h[i] <= sha512_pkg::init_hash(3'(i));
                            r_v[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_valid                 = (r_state == S_OUT);
        o_item.digest_word      = r_h[r_oidx];
        o_item.word_index       = r_oidx;
        o_item.last_digest_word = (r_oidx == 3'd7);
    end
endmodule
`default_nettype wire
